[hw/rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: opcodes and status codes.
// No dependencies.
`default_nettype none
package cau_pkg;
  localparam int unsigned OP_BITS = 3;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CONJ = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_DIVZ = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/cau_if.sv]
// Valid/ready channel interface carrying an opaque payload vector.
// Used by the complex arithmetic unit for its request and result channels.
`default_nettype none
interface cau_if #(
  parameter int unsigned PayloadBits = 1
);
  logic                   valid;
  logic                   ready;
  logic [PayloadBits-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: input decode, products, division cell chain, saturation.
// Depends on cau_pkg, cau_if and cau_div_cell.
//
// Usage: req carries {req_type, a_re, a_im, b_re, b_im}; rsp carries
// {result_re, result_im, status}. One transaction on req gives exactly one
// transaction on rsp, in order. Add, subtract, multiply, divide and conjugate
// all travel through the same pipeline so results never reorder.
// A request passes through the input register, the product register, the chain
// of division cells (one quotient bit per cell; NumBits = 2*WORD_BITS +
// FRAC_BITS + 2 quotient bits, 42 at the defaults) and the output register.
// Throughput: one transaction per cycle. The whole pipeline advances together;
// when rsp is stalled with a valid result at its head, every stage holds and
// req.ready drops, otherwise req.ready stays high.
// Reset clears only the valid bits of the stages; no clearing pass.
// A zero divisor returns zero parts and divide-by-zero status.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cau_if.sink      req,
  cau_if.source    rsp
);
  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned PBits  = 2 * W;             // product magnitude
  localparam int unsigned SBits  = 2 * W + 1;         // sum of two products
  localparam int unsigned NumBits = SBits + FRAC_BITS + 1;
  localparam int unsigned DenBits = SBits;
  localparam int unsigned Stages = NumBits;

  // how the output stage builds the result
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_DIV   = 2'd1;
  localparam logic [1:0] KIND_DIVZ  = 2'd2;

  logic en;

  // stage 1: register the inputs; magnitudes and signs are formed in stage 2 ------
  logic [cau_pkg::OP_BITS-1:0] op;
  logic signed [W-1:0] ar, ai, br, bi;
  assign {op, ar, ai, br, bi} = req.data;

  logic               v1_q;
  logic [cau_pkg::OP_BITS-1:0] op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= req.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op; ar1_q <= ar; ai1_q <= ai; br1_q <= br; bi1_q <= bi;
    end
  end

  // stage 2: six products, signs and the add/sub/conj sums, one register after ----
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? W'(-x) : W'(x);
  endfunction

  logic v2_q;
  logic [cau_pkg::OP_BITS-1:0] op2_q;
  logic [PBits-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_q, p_cc_q;
  logic s_rr_q, s_ii_q, s_ir_q, s_ri_q;
  logic signed [W+1:0] sum_re_q, sum_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q  <= op1_q;
      p_rr_q <= mag(ar1_q) * mag(br1_q);
      p_ii_q <= mag(ai1_q) * mag(bi1_q);
      p_ir_q <= mag(ai1_q) * mag(br1_q);
      p_ri_q <= mag(ar1_q) * mag(bi1_q);
      p_bb_q <= mag(br1_q) * mag(br1_q);
      p_cc_q <= mag(bi1_q) * mag(bi1_q);
      s_rr_q <= ar1_q[W-1] ^ br1_q[W-1];
      s_ii_q <= ai1_q[W-1] ^ bi1_q[W-1];
      s_ir_q <= ai1_q[W-1] ^ br1_q[W-1];
      s_ri_q <= ar1_q[W-1] ^ bi1_q[W-1];
      case (op1_q)
        cau_pkg::OP_ADD: begin
          sum_re_q <= (W+2)'(ar1_q) + (W+2)'(br1_q);
          sum_im_q <= (W+2)'(ai1_q) + (W+2)'(bi1_q);
        end
        cau_pkg::OP_SUB: begin
          sum_re_q <= (W+2)'(ar1_q) - (W+2)'(br1_q);
          sum_im_q <= (W+2)'(ai1_q) - (W+2)'(bi1_q);
        end
        cau_pkg::OP_CONJ: begin
          sum_re_q <= (W+2)'(ar1_q);
          sum_im_q <= -(W+2)'(ai1_q);
        end
        default: begin
          sum_re_q <= '0;
          sum_im_q <= '0;
        end
      endcase
    end
  end

  // ---------------- stage 3: signed sums, start of the division chain -------
  // signed value of +-p, with extra bits for the sum
  function automatic logic signed [SBits:0] sv(input logic [PBits-1:0] p, input logic n);
    sv = n ? -(SBits+1)'(p) : (SBits+1)'(p);
  endfunction

  logic signed [SBits:0] x_re, x_im;
  logic [SBits:0] xm_re, xm_im;
  logic [DenBits-1:0] den;
  logic is_div, is_mul;

  always_comb begin
    is_mul = op2_q == cau_pkg::OP_MUL;
    is_div = op2_q == cau_pkg::OP_DIV;
    if (is_div) begin
      x_re = sv(p_rr_q, s_rr_q) + sv(p_ii_q, s_ii_q);
      x_im = sv(p_ir_q, s_ir_q) - sv(p_ri_q, s_ri_q);
    end else begin
      x_re = sv(p_rr_q, s_rr_q) - sv(p_ii_q, s_ii_q);
      x_im = sv(p_ir_q, s_ir_q) + sv(p_ri_q, s_ri_q);
    end
    xm_re = x_re[SBits] ? (SBits+1)'(-x_re) : (SBits+1)'(x_re);
    xm_im = x_im[SBits] ? (SBits+1)'(-x_im) : (SBits+1)'(x_im);
    den   = DenBits'({1'b0, p_bb_q} + {1'b0, p_cc_q});
  end

  // tag: {kind[1:0], neg_re, neg_im, val_re, val_im};
  // for non-divide ops the final value is computed here and carried along
  localparam int unsigned VBits = W + 2;
  logic [1:0] kind;
  logic signed [VBits-1:0] val_re, val_im;

  // saturate a signed wide value into the range -2**W .. 2**W, which fits in VBits
  function automatic logic signed [VBits-1:0] clampv(input logic signed [SBits:0] x);
    logic signed [SBits:0] hi, lo;
    begin
      hi = (SBits+1)'(2**W);
      lo = -(SBits+1)'(2**W);
      if (x > hi) clampv = VBits'(hi);
      else if (x < lo) clampv = VBits'(lo);
      else clampv = VBits'(x);
    end
  endfunction

  always_comb begin
    logic signed [SBits:0] tr, ti;
    tr = x_re[SBits] ? -(SBits+1)'(xm_re >> FRAC_BITS) : (SBits+1)'(xm_re >> FRAC_BITS);
    ti = x_im[SBits] ? -(SBits+1)'(xm_im >> FRAC_BITS) : (SBits+1)'(xm_im >> FRAC_BITS);
    if (is_div) begin
      kind   = (den == '0) ? KIND_DIVZ : KIND_DIV;
      val_re = '0;
      val_im = '0;
    end else if (is_mul) begin
      kind   = KIND_PLAIN;
      val_re = clampv(tr);
      val_im = clampv(ti);
    end else begin
      kind   = KIND_PLAIN;
      val_re = VBits'(sum_re_q);
      val_im = VBits'(sum_im_q);
    end
  end

  localparam int unsigned CTag = 2 + 2 + 2 * VBits;
  logic [Stages:0]               cv;
  logic [NumBits-1:0]            crr [Stages+1];
  logic [NumBits-1:0]            cri [Stages+1];
  logic [NumBits-1:0]            cqr [Stages+1];
  logic [NumBits-1:0]            cqi [Stages+1];
  logic [NumBits-1:0]            cnr [Stages+1];
  logic [NumBits-1:0]            cni [Stages+1];
  logic [DenBits-1:0]            cd  [Stages+1];
  logic [CTag-1:0]               ct  [Stages+1];

  assign cv[0]  = v2_q;
  assign crr[0] = '0;
  assign cri[0] = '0;
  assign cqr[0] = '0;
  assign cqi[0] = '0;
  assign cnr[0] = NumBits'({xm_re, {FRAC_BITS{1'b0}}});
  assign cni[0] = NumBits'({xm_im, {FRAC_BITS{1'b0}}});
  assign cd[0]  = (den == '0) ? DenBits'(1) : den;
  assign ct[0]  = {kind, x_re[SBits], x_im[SBits], val_re, val_im};

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    cau_div_cell #(
      .NumBits(NumBits), .DenBits(DenBits), .TagBits(CTag)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[g]), .rem_re_i(crr[g]), .rem_im_i(cri[g]),
      .quo_re_i(cqr[g]), .quo_im_i(cqi[g]), .den_i(cd[g]), .tag_i(ct[g]),
      .num_re_i(cnr[g]), .num_im_i(cni[g]),
      .valid_o(cv[g+1]), .rem_re_o(crr[g+1]), .rem_im_o(cri[g+1]),
      .quo_re_o(cqr[g+1]), .quo_im_o(cqi[g+1]), .den_o(cd[g+1]), .tag_o(ct[g+1]),
      .num_re_o(cnr[g+1]), .num_im_o(cni[g+1])
    );
  end

  // ---------------- output stage: saturation --------------------------------
  logic [1:0] fk;
  logic fnr, fni;
  logic signed [VBits-1:0] fvr, fvi;
  assign {fk, fnr, fni, fvr, fvi} = ct[Stages];

  function automatic logic [W-1:0] satq(input logic [NumBits-1:0] q, input logic n,
                                        output logic ov);
    logic [NumBits:0] half;
    begin
      half = (NumBits+1)'(2**(W-1));
      ov = 1'b0;
      if (n) begin
        if ({1'b0, q} > half) begin ov = 1'b1; satq = {1'b1, {(W-1){1'b0}}}; end
        else satq = W'(-q);
      end else begin
        if ({1'b0, q} > half - 1) begin ov = 1'b1; satq = {1'b0, {(W-1){1'b1}}}; end
        else satq = W'(q);
      end
    end
  endfunction

  function automatic logic [W-1:0] satv(input logic signed [VBits-1:0] v, output logic ov);
    begin
      ov = 1'b0;
      if (v > VBits'(2**(W-1) - 1)) begin ov = 1'b1; satv = {1'b0, {(W-1){1'b1}}}; end
      else if (v < -VBits'(2**(W-1))) begin ov = 1'b1; satv = {1'b1, {(W-1){1'b0}}}; end
      else satv = W'(v);
    end
  endfunction

  logic [W-1:0] o_re, o_im;
  logic [cau_pkg::STATUS_BITS-1:0] o_st;
  always_comb begin
    logic o1, o2;
    o1 = 1'b0;
    o2 = 1'b0;
    case (fk)
      KIND_DIV: begin
        o_re = satq(cqr[Stages], fnr, o1);
        o_im = satq(cqi[Stages], fni, o2);
      end
      KIND_DIVZ: begin
        o_re = '0;
        o_im = '0;
      end
      default: begin
        o_re = satv(fvr, o1);
        o_im = satv(fvi, o2);
      end
    endcase
    if (fk == KIND_DIVZ) o_st = cau_pkg::ST_DIVZ;
    else if (o1 || o2) o_st = cau_pkg::ST_SAT;
    else o_st = cau_pkg::ST_OK;
  end

  logic rv_q;
  logic [2*W+cau_pkg::STATUS_BITS-1:0] rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (en) rv_q <= cv[Stages];
  end
  always_ff @(posedge clk_i) begin
    if (en) rd_q <= {o_re, o_im, o_st};
  end

  assign rsp.valid = rv_q;
  assign rsp.data  = rd_q;
endmodule
`default_nettype wire

[hw/rtl/cau_div_cell.sv]
// One restoring-division cell: produces one quotient bit per stage for both lanes.
// No package dependencies; instantiated in a chain by the top level.
`default_nettype none
module cau_div_cell #(
  parameter int unsigned NumBits = 64,
  parameter int unsigned DenBits = 64,
  parameter int unsigned TagBits = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [NumBits-1:0] rem_re_i,
  input  wire logic [NumBits-1:0] rem_im_i,
  input  wire logic [NumBits-1:0] quo_re_i,
  input  wire logic [NumBits-1:0] quo_im_i,
  input  wire logic [DenBits-1:0] den_i,
  input  wire logic [TagBits-1:0] tag_i,
  input  wire logic [NumBits-1:0] num_re_i,
  input  wire logic [NumBits-1:0] num_im_i,
  output logic                    valid_o,
  output logic      [NumBits-1:0] rem_re_o,
  output logic      [NumBits-1:0] rem_im_o,
  output logic      [NumBits-1:0] quo_re_o,
  output logic      [NumBits-1:0] quo_im_o,
  output logic      [DenBits-1:0] den_o,
  output logic      [TagBits-1:0] tag_o,
  output logic      [NumBits-1:0] num_re_o,
  output logic      [NumBits-1:0] num_im_o
);
  // shift remainder left by one, bring in the next numerator bit, subtract if it fits
  logic [NumBits:0] sh_re, sh_im;
  logic             fit_re, fit_im;

  always_comb begin
    sh_re  = {rem_re_i, num_re_i[NumBits-1]};
    sh_im  = {rem_im_i, num_im_i[NumBits-1]};
    fit_re = sh_re >= {{(NumBits+1-DenBits){1'b0}}, den_i};
    fit_im = sh_im >= {{(NumBits+1-DenBits){1'b0}}, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_o <= fit_re ? NumBits'(sh_re - {{(NumBits+1-DenBits){1'b0}}, den_i})
                         : NumBits'(sh_re);
      rem_im_o <= fit_im ? NumBits'(sh_im - {{(NumBits+1-DenBits){1'b0}}, den_i})
                         : NumBits'(sh_im);
      quo_re_o <= {quo_re_i[NumBits-2:0], fit_re};
      quo_im_o <= {quo_im_i[NumBits-2:0], fit_im};
      num_re_o <= {num_re_i[NumBits-2:0], 1'b0};
      num_im_o <= {num_im_i[NumBits-2:0], 1'b0};
      den_o    <= den_i;
      tag_o    <= tag_i;
    end
  end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the complex arithmetic unit: random and directed complex operations
// checked against an in-order scoreboard. Depends on cau_pkg, cau_if and the dut.
`timescale 1ns / 100ps

module tb_top;
  localparam int unsigned W = 16;
  localparam int unsigned F = 8;
  localparam int unsigned REQ_BITS = cau_pkg::OP_BITS + 4 * W;
  localparam int unsigned RSP_BITS = 2 * W + cau_pkg::STATUS_BITS;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [cau_pkg::OP_BITS-1:0] op;
    logic signed [W-1:0]    ar;
    logic signed [W-1:0]    ai;
    logic signed [W-1:0]    br;
    logic signed [W-1:0]    bi;
  } cplx_req_t;

  typedef struct packed {
    logic signed [W-1:0]     re;
    logic signed [W-1:0]     im;
    logic [cau_pkg::STATUS_BITS-1:0] st;
  } cplx_rsp_t;

  // saturate a wide signed value to W bits
  function automatic logic signed [W-1:0] clamp(longint v, ref bit over);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -(longint'(1) <<< (W - 1));
    if (v > hi) begin
      over = 1;
      return hi[W-1:0];
    end
    if (v < lo) begin
      over = 1;
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // (n << F) / d truncated toward zero; magnitudes stay far below 64 bits
  function automatic longint frac_quot(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m <<< F) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_rsp_t cplx_calc(cplx_req_t r);
    cplx_rsp_t o;
    longint ar, ai, br, bi, re, im, d;
    bit over;
    ar = r.ar; ai = r.ai; br = r.br; bi = r.bi;
    re = 0; im = 0; over = 0;
    o.st = cau_pkg::ST_OK;
    case (r.op)
      cau_pkg::OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) / (longint'(1) <<< F);
        im = (ai * br + ar * bi) / (longint'(1) <<< F);
      end
      cau_pkg::OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) o.st = cau_pkg::ST_DIVZ;
        else begin
          re = frac_quot(ar * br + ai * bi, d);
          im = frac_quot(ai * br - ar * bi, d);
        end
      end
      cau_pkg::OP_CONJ: begin
        re = ar; im = -ai;
      end
      default: ;
    endcase
    o.re = clamp(re, over);
    o.im = clamp(im, over);
    if (o.st == cau_pkg::ST_OK && over) o.st = cau_pkg::ST_SAT;
    return o;
  endfunction

  class cplx_scoreboard;
    cplx_rsp_t pending[$];
    int errors = 0;

    function void note_request(cplx_req_t r);
      pending.push_back(cplx_calc(r));
    endfunction

    function void check_result(cplx_rsp_t got);
      cplx_rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re) begin
        $display("%0t: re expected %0d actual %0d", $time, want.re, got.re);
        errors++;
      end
      if (got.im !== want.im) begin
        $display("%0t: im expected %0d actual %0d", $time, want.im, got.im);
        errors++;
      end
      if (got.st !== want.st) begin
        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #1 clk_i = ~clk_i;

  cau_if #(.PayloadBits(REQ_BITS)) req_ch ();
  cau_if #(.PayloadBits(RSP_BITS)) rsp_ch ();

  complex_arithmetic_unit #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  cplx_scoreboard board = new();
  int stall_cycles = 0;
  bit sending_done = 0;

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return W'($signed($urandom_range(0, 1024)) - 512);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send_req(cplx_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(r);
  endtask

  task automatic send_all();
    cplx_req_t r;
    logic [W-1:0] ext[4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    for (int op = 0; op < 8; op++) begin
      r.op = cau_pkg::OP_BITS'(op);
      r.ar = ext[op % 4]; r.ai = ext[(op + 1) % 4];
      r.br = ext[(op + 2) % 4]; r.bi = ext[(op + 3) % 4];
      send_req(r);
    end
    // zero divisor, conjugate of the most negative imaginary part, overflow
    r = '{cau_pkg::OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000};
    send_req(r);
    r = '{cau_pkg::OP_CONJ, 16'h1234, 16'h8000, 16'h5555, 16'h0000};
    send_req(r);
    r = '{cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send_req(r);
    r = '{cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000};
    send_req(r);
    r = '{cau_pkg::OP_DIV, 16'h8000, 16'h0000, 16'h8000, 16'h8000};
    send_req(r);
    r = '{cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
    send_req(r);
    r = '{cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};
    send_req(r);
    for (int n = 0; n < 800; n++) begin
      r.op = ($urandom_range(0, 19) == 0) ? cau_pkg::OP_BITS'($urandom_range(5, 7))
                                          : cau_pkg::OP_BITS'($urandom_range(0, 4));
      r.ar = pick_word(); r.ai = pick_word();
      r.br = pick_word(); r.bi = pick_word();
      send_req(r);
    end
    req_ch.valid <= 0;
    sending_done = 1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_all();
  end

  // sink side: random stalls, results sampled at the accepting edge
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      board.check_result(cplx_rsp_t'(rsp_ch.data));
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_cycles >= STALL_LIMIT) begin
        $display("complex_arithmetic_unit test failed");
        $finish;
      end
      if (sending_done && board.pending.size() == 0) begin
        repeat (60) @(posedge clk_i);
        if (board.errors == 0 && board.pending.size() == 0)
          $display("complex_arithmetic_unit test passed");
        else
          $display("complex_arithmetic_unit test failed");
        $finish;
      end
    end
  end
endmodule
